[rtl/core/i2c_byte_master_assert.svh]
// Assertion macros used by the I2C byte master sequencer.
`ifndef I2C_BYTE_MASTER_ASSERT_SVH
`define I2C_BYTE_MASTER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define IBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define IBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ibm_pkg.sv]
// Package with types and constants of the I2C byte master.
package ibm_pkg;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0]  MSB_MASK        = 8'h80;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_PHASE_TICKS = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_STA_A   = 5'd1,
    ST_STA_B   = 5'd2,
    ST_FINISH  = 5'd3,
    ST_STO_A   = 5'd4,
    ST_STO_B   = 5'd5,
    ST_WR_HI   = 5'd7,
    ST_WR_LO   = 5'd8,
    ST_WA_HI   = 5'd9,
    ST_WA_POLL = 5'd10,
    ST_RD_SMP  = 5'd12,
    ST_RD_NEXT = 5'd13,
    ST_AK_HI   = 5'd14,
    ST_AK_LO   = 5'd15,
    ST_AK_REL  = 5'd16
  } step_e;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

endpackage

[rtl/core/i2c_byte_master.sv]
// Top level of the I2C byte master: tick input register, sequencer, result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  in       | in_valid_i / in_stall_o     | cmd_valid_i mode_i tx_byte_i send_nack_i sda_in_i
//  out      | out_valid_o / out_stall_i   | scl_out_o sda_out_o busy_res_o done_res_o
//           |                             | rx_byte_o ack_error_o
//  cfg      | APB psel/penable/pready     | paddr pwdata prdata
//
// One tick transfer per cycle unless the output stalls; the result follows in the next cycle.
// The state update of the sequencer is the single combinational step per tick.
// Reset leaves the sequencer's pin levels high and it idle, both pipeline stages empty.
// A stalled output holds both the result register and the input register; ticks resume
// at full rate as soon as out_stall_i drops.
module i2c_byte_master #(
  parameter int PHASE_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_valid_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        send_nack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ibm_pkg::cfg_t  cfg;
  ibm_pkg::item_t item_q;
  ibm_pkg::res_t  res, res_q;
  logic           in_vld_q, out_vld_q;
  logic           advance, tick;

  assign advance    = !out_vld_q || !out_stall_i;
  assign tick       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  ibm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ibm_seq #(
    .PHASE_COUNT_BITS (PHASE_COUNT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.cmd_valid <= cmd_valid_i;
      item_q.mode      <= mode_i;
      item_q.tx_byte   <= tx_byte_i;
      item_q.send_nack <= send_nack_i;
      item_q.sda_in    <= sda_in_i;
    end
    if (tick) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign scl_out_o   = res_q.scl_out;
  assign sda_out_o   = res_q.sda_out;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign rx_byte_o   = res_q.rx_byte;
  assign ack_error_o = res_q.ack_error;

endmodule

[rtl/core/ibm_cfg.sv]
// APB register file holding phase length and acknowledge timeout.
module ibm_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ibm_pkg::cfg_t     cfg_o
);

  logic [15:0] phase_q;
  logic [7:0]  tmo_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ibm_pkg::PHASE_TICKS_RST;
      tmo_q   <= ibm_pkg::ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (ibm_pkg::reg_e'(paddr[2]))
        ibm_pkg::REG_PHASE_TICKS: phase_q <= pwdata[15:0];
        ibm_pkg::REG_ACK_TIMEOUT: tmo_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ibm_pkg::reg_e'(paddr[2]))
      ibm_pkg::REG_PHASE_TICKS: prdata = {16'd0, phase_q};
      ibm_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, tmo_q};
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.phase_ticks = phase_q;
  assign cfg_o.ack_timeout = tmo_q;

endmodule

[rtl/core/ibm_seq.sv]
// Bus sequencer: command state, pin levels and byte shifting, one tick per transfer.
`include "i2c_byte_master_assert.svh"
module ibm_seq #(
  parameter int PHASE_COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tick_i,
  input  ibm_pkg::item_t item_i,
  input  ibm_pkg::cfg_t  cfg_i,
  output ibm_pkg::res_t  res_o
);

  localparam int PCB = PHASE_COUNT_BITS;

  ibm_pkg::step_e   step_q, step_d;
  logic [PCB-1:0]   ph_q, ph_d, ph_load, ph_mask;
  logic [3:0]       bit_q, bit_d, bit_inc;
  logic [7:0]       sr_q, sr_d, sr_shl;
  logic [7:0]       wc_q, wc_d;
  logic             scl_q, scl_d, sda_q, sda_d;
  logic             nack_q, nack_d, err_q, err_d;
  logic [7:0]       rx_q, rx_d;
  logic             done;

  // phase load: phase_ticks cut or widened to the counter, zero acts as one
  always_comb begin
    ph_mask = '0;
    for (int i = 0; i < PCB; i++) begin
      if (i < 16) begin
        ph_mask[i] = cfg_i.phase_ticks[i];
      end
    end
    ph_load = (ph_mask == '0) ? PCB'(1) : ph_mask;
  end

  assign bit_inc = bit_q + 4'd1;
  assign sr_shl  = {sr_q[6:0], 1'b0};

  always_comb begin
    step_d = step_q;
    ph_d   = ph_q;
    bit_d  = bit_q;
    sr_d   = sr_q;
    wc_d   = wc_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    nack_d = nack_q;
    err_d  = err_q;
    rx_d   = rx_q;
    done   = 1'b0;
    if (tick_i) begin
      if (step_q == ibm_pkg::ST_IDLE) begin
        if (item_i.cmd_valid) begin
          ph_d = ph_load;
          unique case (ibm_pkg::cmd_e'(item_i.mode))
            ibm_pkg::CMD_START: begin
              sda_d  = 1'b1;
              scl_d  = 1'b1;
              step_d = ibm_pkg::ST_STA_A;
            end
            ibm_pkg::CMD_STOP: begin
              sda_d  = 1'b0;
              step_d = ibm_pkg::ST_STO_A;
            end
            ibm_pkg::CMD_WRITE: begin
              err_d  = 1'b0;
              sr_d   = item_i.tx_byte;
              bit_d  = '0;
              sda_d  = |(item_i.tx_byte & ibm_pkg::MSB_MASK);
              step_d = ibm_pkg::ST_WR_HI;
            end
            ibm_pkg::CMD_READ: begin
              sr_d   = '0;
              bit_d  = '0;
              nack_d = item_i.send_nack;
              sda_d  = 1'b1;
              scl_d  = 1'b1;
              step_d = ibm_pkg::ST_RD_SMP;
            end
            default: ;
          endcase
        end
      end else if (step_q == ibm_pkg::ST_WA_POLL) begin
        ph_d = '0;
        if (!item_i.sda_in) begin
          scl_d  = 1'b0;
          ph_d   = ph_load;
          step_d = ibm_pkg::ST_FINISH;
        end else if (wc_q >= cfg_i.ack_timeout) begin
          err_d  = 1'b1;
          sda_d  = 1'b0;
          ph_d   = ph_load;
          step_d = ibm_pkg::ST_STO_A;
        end else begin
          wc_d = wc_q + 8'd1;
        end
      end else if (ph_q > PCB'(1)) begin
        ph_d = ph_q - PCB'(1);
      end else begin
        ph_d = ph_load;
        unique case (step_q)
          ibm_pkg::ST_STA_A: begin
            sda_d  = 1'b0;
            step_d = ibm_pkg::ST_STA_B;
          end
          ibm_pkg::ST_STA_B: begin
            scl_d  = 1'b0;
            step_d = ibm_pkg::ST_FINISH;
          end
          ibm_pkg::ST_FINISH: begin
            ph_d   = '0;
            done   = 1'b1;
            step_d = ibm_pkg::ST_IDLE;
          end
          ibm_pkg::ST_STO_A: begin
            scl_d  = 1'b1;
            step_d = ibm_pkg::ST_STO_B;
          end
          ibm_pkg::ST_STO_B: begin
            sda_d  = 1'b1;
            step_d = ibm_pkg::ST_FINISH;
          end
          ibm_pkg::ST_WR_HI: begin
            scl_d  = 1'b1;
            step_d = ibm_pkg::ST_WR_LO;
          end
          ibm_pkg::ST_WR_LO: begin
            scl_d = 1'b0;
            sr_d  = sr_shl;
            bit_d = bit_inc;
            if (bit_inc < ibm_pkg::BITS_PER_BYTE) begin
              sda_d  = sr_shl[7];
              step_d = ibm_pkg::ST_WR_HI;
            end else begin
              sda_d  = 1'b1;
              step_d = ibm_pkg::ST_WA_HI;
            end
          end
          ibm_pkg::ST_WA_HI: begin
            scl_d  = 1'b1;
            wc_d   = '0;
            step_d = ibm_pkg::ST_WA_POLL;
          end
          ibm_pkg::ST_RD_SMP: begin
            sr_d   = {sr_q[6:0], item_i.sda_in};
            scl_d  = 1'b0;
            bit_d  = bit_inc;
            step_d = ibm_pkg::ST_RD_NEXT;
          end
          ibm_pkg::ST_RD_NEXT: begin
            if (bit_q < ibm_pkg::BITS_PER_BYTE) begin
              scl_d  = 1'b1;
              step_d = ibm_pkg::ST_RD_SMP;
            end else begin
              rx_d   = sr_q;
              sda_d  = nack_q;
              step_d = ibm_pkg::ST_AK_HI;
            end
          end
          ibm_pkg::ST_AK_HI: begin
            scl_d  = 1'b1;
            step_d = ibm_pkg::ST_AK_LO;
          end
          ibm_pkg::ST_AK_LO: begin
            scl_d  = 1'b0;
            step_d = nack_q ? ibm_pkg::ST_FINISH : ibm_pkg::ST_AK_REL;
          end
          ibm_pkg::ST_AK_REL: begin
            sda_d  = 1'b1;
            step_d = ibm_pkg::ST_FINISH;
          end
          default: begin
            ph_d   = '0;
            step_d = ibm_pkg::ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ibm_pkg::ST_IDLE;
      ph_q   <= '0;
      bit_q  <= '0;
      sr_q   <= '0;
      wc_q   <= '0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      nack_q <= 1'b0;
      err_q  <= 1'b0;
      rx_q   <= '0;
    end else begin
      step_q <= step_d;
      ph_q   <= ph_d;
      bit_q  <= bit_d;
      sr_q   <= sr_d;
      wc_q   <= wc_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      nack_q <= nack_d;
      err_q  <= err_d;
      rx_q   <= rx_d;
    end
  end

  assign res_o.scl_out   = scl_d;
  assign res_o.sda_out   = sda_d;
  assign res_o.busy_res  = (step_d != ibm_pkg::ST_IDLE);
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = rx_d;
  assign res_o.ack_error = err_d;

  `IBM_ASSERT_NXT(a_hold_no_tick, !tick_i, $stable(step_q) && $stable(ph_q), "state moved without a tick")
  `IBM_ASSERT_NXT(a_idle_no_cmd, tick_i && step_q == ibm_pkg::ST_IDLE && !item_i.cmd_valid, step_q == ibm_pkg::ST_IDLE, "left idle without a command")
  `IBM_ASSERT_IMP(a_phase_loaded, step_q != ibm_pkg::ST_IDLE && step_q != ibm_pkg::ST_WA_POLL, ph_q != '0, "phase counter empty in a timed step")
  `IBM_ASSERT_IMP(a_bit_range, 1'b1, bit_q <= ibm_pkg::BITS_PER_BYTE, "bit counter past one byte")

endmodule

[dv/testbench.sv]
// Testbench for i2c_byte_master: per-tick bus predictor, random handshakes, APB register setup.
`timescale 1ns / 1ps

module testbench;

  localparam int ITEMS_TOTAL = 1150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_valid_i = 1'b0;
  logic [1:0]  mode_i = '0;
  logic [7:0]  tx_byte_i = '0;
  logic        send_nack_i = 1'b0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        ack_error_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_byte_master uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_valid_i(cmd_valid_i), .mode_i(mode_i), .tx_byte_i(tx_byte_i),
    .send_nack_i(send_nack_i), .sda_in_i(sda_in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .scl_out_o(scl_out_o), .sda_out_o(sda_out_o), .busy_res_o(busy_res_o),
    .done_res_o(done_res_o), .rx_byte_o(rx_byte_o), .ack_error_o(ack_error_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0]     cfg_phase = ibm_pkg::PHASE_TICKS_RST;
  logic [7:0]      cfg_timeout = ibm_pkg::ACK_TIMEOUT_RST;
  ibm_pkg::step_e  seq_step = ibm_pkg::ST_IDLE;
  logic [15:0]     phase_cnt = '0;
  logic [3:0]      bit_cnt = '0;
  logic [7:0]      shreg = '0;
  logic [7:0]      wait_cnt = '0;
  logic [7:0]      rx_hold = '0;
  logic            scl_lvl = 1'b1;
  logic            sda_lvl = 1'b1;
  logic            nack_flg = 1'b0;
  logic            err_flg = 1'b0;

  ibm_pkg::res_t   bus_state_q[$];
  int              errors = 0;
  int              ticks_sent = 0;
  bit              no_gaps = 1'b0;
  bit              no_stalls = 1'b0;
  bit              hold_req = 1'b0;

  // slave behavior for the running command
  int              ack_wait = 0;
  logic [7:0]      slave_byte = '0;

  function automatic void load_phase(ibm_pkg::step_e nxt);
    phase_cnt = (cfg_phase == '0) ? 16'd1 : cfg_phase;
    seq_step = nxt;
  endfunction

  function automatic void begin_stop();
    sda_lvl = 1'b0;
    load_phase(ibm_pkg::ST_STO_A);
  endfunction

  function automatic ibm_pkg::res_t next_bus_state(ibm_pkg::item_t t);
    ibm_pkg::res_t r;
    logic done;
    done = 1'b0;
    if (seq_step == ibm_pkg::ST_IDLE) begin
      if (t.cmd_valid) begin
        case (ibm_pkg::cmd_e'(t.mode))
          ibm_pkg::CMD_START: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            load_phase(ibm_pkg::ST_STA_A);
          end
          ibm_pkg::CMD_STOP: begin_stop();
          ibm_pkg::CMD_WRITE: begin
            err_flg = 1'b0;
            shreg = t.tx_byte;
            bit_cnt = '0;
            sda_lvl = t.tx_byte[7];
            load_phase(ibm_pkg::ST_WR_HI);
          end
          default: begin
            shreg = '0;
            bit_cnt = '0;
            nack_flg = t.send_nack;
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            load_phase(ibm_pkg::ST_RD_SMP);
          end
        endcase
      end
    end else if (seq_step != ibm_pkg::ST_WA_POLL && phase_cnt > 16'd1) begin
      phase_cnt--;
    end else begin
      phase_cnt = '0;
      case (seq_step)
        ibm_pkg::ST_STA_A: begin sda_lvl = 1'b0; load_phase(ibm_pkg::ST_STA_B); end
        ibm_pkg::ST_STA_B: begin scl_lvl = 1'b0; load_phase(ibm_pkg::ST_FINISH); end
        ibm_pkg::ST_FINISH: begin seq_step = ibm_pkg::ST_IDLE; done = 1'b1; end
        ibm_pkg::ST_STO_A: begin scl_lvl = 1'b1; load_phase(ibm_pkg::ST_STO_B); end
        ibm_pkg::ST_STO_B: begin sda_lvl = 1'b1; load_phase(ibm_pkg::ST_FINISH); end
        ibm_pkg::ST_WR_HI: begin scl_lvl = 1'b1; load_phase(ibm_pkg::ST_WR_LO); end
        ibm_pkg::ST_WR_LO: begin
          scl_lvl = 1'b0;
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt < ibm_pkg::BITS_PER_BYTE) begin
            sda_lvl = shreg[7];
            load_phase(ibm_pkg::ST_WR_HI);
          end else begin
            sda_lvl = 1'b1;
            load_phase(ibm_pkg::ST_WA_HI);
          end
        end
        ibm_pkg::ST_WA_HI: begin
          scl_lvl = 1'b1;
          wait_cnt = '0;
          load_phase(ibm_pkg::ST_WA_POLL);
        end
        ibm_pkg::ST_WA_POLL: begin
          if (!t.sda_in) begin
            scl_lvl = 1'b0;
            load_phase(ibm_pkg::ST_FINISH);
          end else if (wait_cnt >= cfg_timeout) begin
            err_flg = 1'b1;
            begin_stop();
          end else begin
            wait_cnt = wait_cnt + 8'd1;
          end
        end
        ibm_pkg::ST_RD_SMP: begin
          shreg = {shreg[6:0], t.sda_in};
          scl_lvl = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          load_phase(ibm_pkg::ST_RD_NEXT);
        end
        ibm_pkg::ST_RD_NEXT: begin
          if (bit_cnt < ibm_pkg::BITS_PER_BYTE) begin
            scl_lvl = 1'b1;
            load_phase(ibm_pkg::ST_RD_SMP);
          end else begin
            rx_hold = shreg;
            sda_lvl = nack_flg;
            load_phase(ibm_pkg::ST_AK_HI);
          end
        end
        ibm_pkg::ST_AK_HI: begin scl_lvl = 1'b1; load_phase(ibm_pkg::ST_AK_LO); end
        ibm_pkg::ST_AK_LO: begin
          scl_lvl = 1'b0;
          load_phase(nack_flg ? ibm_pkg::ST_FINISH : ibm_pkg::ST_AK_REL);
        end
        ibm_pkg::ST_AK_REL: begin sda_lvl = 1'b1; load_phase(ibm_pkg::ST_FINISH); end
        default: seq_step = ibm_pkg::ST_IDLE;
      endcase
    end
    r.scl_out = scl_lvl;
    r.sda_out = sda_lvl;
    r.busy_res = (seq_step != ibm_pkg::ST_IDLE);
    r.done_res = done;
    r.rx_byte = rx_hold;
    r.ack_error = err_flg;
    return r;
  endfunction

  // tick as the slave would drive SDA; other fields random, commands only as noise
  function automatic ibm_pkg::item_t slave_tick(bit noise);
    ibm_pkg::item_t t;
    t.cmd_valid = noise && (seq_step != ibm_pkg::ST_IDLE) &&
                  ($urandom_range(0, 3) == 0);
    t.mode = 2'($urandom_range(0, 3));
    t.tx_byte = 8'($urandom_range(0, 255));
    t.send_nack = 1'($urandom_range(0, 1));
    if (seq_step == ibm_pkg::ST_RD_SMP && phase_cnt <= 16'd1)
      t.sda_in = slave_byte[~bit_cnt[2:0]];
    else if (seq_step == ibm_pkg::ST_WA_POLL)
      t.sda_in = (wait_cnt < ack_wait);
    else
      t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(ibm_pkg::item_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_valid_i <= t.cmd_valid;
    mode_i      <= t.mode;
    tx_byte_i   <= t.tx_byte;
    send_nack_i <= t.send_nack;
    sda_in_i    <= t.sda_in;
    do @(posedge clk_i); while (in_stall_o);
    bus_state_q.push_back(next_bus_state(t));
    ticks_sent++;
  endtask

  task automatic run_cmd(ibm_pkg::cmd_e c, logic [7:0] data, logic nack, int ackw,
                         bit noise);
    ibm_pkg::item_t t;
    slave_byte = data;
    ack_wait = ackw;
    t = slave_tick(1'b0);
    t.cmd_valid = 1'b1;
    t.mode = c;
    t.tx_byte = data;
    t.send_nack = nack;
    send_tick(t);
    while (seq_step != ibm_pkg::ST_IDLE) send_tick(slave_tick(noise));
  endtask

  task automatic set_reg(ibm_pkg::reg_e r, logic [31:0] v);
    logic [31:0] want;
    while (seq_step != ibm_pkg::ST_IDLE) send_tick(slave_tick(1'b0));
    in_valid_i <= 1'b0;
    while (bus_state_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = (r == ibm_pkg::REG_PHASE_TICKS) ? {16'd0, v[15:0]} : {24'd0, v[7:0]};
    if (prdata !== want) begin
      $error("register %s readback: expected %0h, actual %0h", r.name(), want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == ibm_pkg::REG_PHASE_TICKS)
      cfg_phase = v[15:0];
    else
      cfg_timeout = v[7:0];
  endtask

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    ibm_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_state_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = bus_state_q.pop_front();
        cmp_field("scl_out", 8'(want.scl_out), 8'(scl_out_o));
        cmp_field("sda_out", 8'(want.sda_out), 8'(sda_out_o));
        cmp_field("busy_res", 8'(want.busy_res), 8'(busy_res_o));
        cmp_field("done_res", 8'(want.done_res), 8'(done_res_o));
        cmp_field("rx_byte", want.rx_byte, rx_byte_o);
        cmp_field("ack_error", 8'(want.ack_error), 8'(ack_error_o));
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 80;
      end else if (out_valid_o && !out_stall_i) begin
        stall_left = no_stalls ? 0 : $urandom_range(0, 5);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic test_defaults();
    run_cmd(ibm_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(ibm_pkg::CMD_WRITE, 8'h5A, 1'b0, 1, 1'b0);
    run_cmd(ibm_pkg::CMD_READ, 8'hC3, 1'b1, 0, 1'b0);
    run_cmd(ibm_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  task automatic test_commands();
    set_reg(ibm_pkg::REG_PHASE_TICKS, 32'd1);
    set_reg(ibm_pkg::REG_ACK_TIMEOUT, 32'd3);
    run_cmd(ibm_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(ibm_pkg::CMD_WRITE, 8'hFF, 1'b0, 0, 1'b0);
    run_cmd(ibm_pkg::CMD_WRITE, 8'h00, 1'b1, 3, 1'b0);
    run_cmd(ibm_pkg::CMD_WRITE, 8'hA5, 1'b0, 4, 1'b0);
    run_cmd(ibm_pkg::CMD_READ, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(ibm_pkg::CMD_READ, 8'hFF, 1'b1, 0, 1'b0);
    run_cmd(ibm_pkg::CMD_READ, 8'h96, 1'b0, 0, 1'b1);
    run_cmd(ibm_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b1);
    run_cmd(ibm_pkg::CMD_START, 8'hFF, 1'b1, 0, 1'b1);
    // zero phase length behaves as one tick
    set_reg(ibm_pkg::REG_PHASE_TICKS, 32'd0);
    run_cmd(ibm_pkg::CMD_WRITE, 8'h3C, 1'b0, 2, 1'b1);
    run_cmd(ibm_pkg::CMD_READ, 8'h81, 1'b1, 0, 1'b1);
  endtask

  task automatic test_ack_timeout();
    set_reg(ibm_pkg::REG_PHASE_TICKS, 32'd1);
    set_reg(ibm_pkg::REG_ACK_TIMEOUT, 32'd255);
    run_cmd(ibm_pkg::CMD_WRITE, 8'h12, 1'b0, 256, 1'b0);
    set_reg(ibm_pkg::REG_ACK_TIMEOUT, 32'd1);
    run_cmd(ibm_pkg::CMD_WRITE, 8'h81, 1'b0, 1, 1'b0);
    run_cmd(ibm_pkg::CMD_WRITE, 8'h7E, 1'b0, 2, 1'b0);
  endtask

  task automatic test_max_phase();
    set_reg(ibm_pkg::REG_PHASE_TICKS, 32'h0000_FFFF);
    // upper data bits are dropped by the register
    set_reg(ibm_pkg::REG_PHASE_TICKS, 32'hA5A5_0013);
    set_reg(ibm_pkg::REG_ACK_TIMEOUT, 32'h0000_1202);
    no_gaps = 1'b1;
    no_stalls = 1'b1;
    run_cmd(ibm_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b1);
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  task automatic test_backpressure();
    set_reg(ibm_pkg::REG_PHASE_TICKS, 32'd1);
    set_reg(ibm_pkg::REG_ACK_TIMEOUT, 32'd4);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    run_cmd(ibm_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b1);
    run_cmd(ibm_pkg::CMD_WRITE, 8'hA0, 1'b0, 2, 1'b1);
    run_cmd(ibm_pkg::CMD_READ, 8'h5C, 1'b1, 0, 1'b1);
    run_cmd(ibm_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b1);
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    int ops;
    logic [7:0] tmo;
    while (ticks_sent < ITEMS_TOTAL) begin
      if ($urandom_range(0, 7) == 0) begin
        set_reg(ibm_pkg::REG_PHASE_TICKS,
                ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 32'd1);
        tmo = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
        set_reg(ibm_pkg::REG_ACK_TIMEOUT, {24'd0, tmo});
      end
      no_gaps = ($urandom_range(0, 5) == 0);
      no_stalls = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_tick(slave_tick(1'b0));
        1: run_cmd(ibm_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                   $urandom_range(0, cfg_timeout + 1), 1'b1);
        default: begin
          run_cmd(ibm_pkg::CMD_START, 8'($urandom), 1'($urandom), 0, 1'b1);
          ops = $urandom_range(1, 3);
          for (int i = 0; i < ops; i++) begin
            if (i == 0 || $urandom_range(0, 1) == 0)
              run_cmd(ibm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom),
                      $urandom_range(0, cfg_timeout + 1), 1'b1);
            else
              run_cmd(ibm_pkg::CMD_READ, 8'($urandom), (i == ops - 1), 0, 1'b1);
          end
          run_cmd(ibm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 0, 1'b1);
        end
      endcase
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_commands();
    test_ack_timeout();
    test_max_phase();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    while (bus_state_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
